// ===== hw/rtl/tprt_pkg.sv =====
// ----------------------------------------------------------------------------
// tprt_pkg
// Shared widths, register indexes, phase codes and control types of the
// trapezoid profile unit.
// ----------------------------------------------------------------------------
package tprt_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam int SPEED_W   = 16;
    localparam int LEN_W     = 20;
    localparam int DIR_W     = 2;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int TSTAMP_W  = 32;
    localparam int ANG_W     = 17;
    localparam int PHASE_W   = 3;

    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = 62;
    localparam int DEN_W   = 42;

    localparam logic [MUL_B_W-1:0] US_PER_S = 20'd1000000;
    localparam logic [PROD_W-1:0]  ROUND_UP = 62'd999999;

    // divide by one million: drop six bits, then multiply by 2^45/15625 rounded up
    localparam int          RCP_PRE   = 6;
    localparam int          RCP_IN_W  = 31;
    localparam int          RCP_SHIFT = 45;
    localparam logic [31:0] RCP_MUL   = 32'd2251799814;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_FIRST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_CURVE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_SECOND    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_DIR      = 3'd6;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ACCEL  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CRUISE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DECEL  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd4;

    typedef enum logic [3:0] {
        STEP_VSQ,
        STEP_VMAC,
        STEP_TOTAL,
        STEP_FIRST,
        STEP_ATIME,
        STEP_CTIME,
        STEP_COFF,
        STEP_RTIME,
        STEP_ITEM
    } step_t;

    typedef struct packed {
        logic  load_in;
        logic  eval;
        logic  mul_en;
        logic  div_start;
        logic  rcp_load;
        logic  store;
        logic  out_load;
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic start;
        logic need_job;
        logic skip;
        logic const_div;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== hw/rtl/tprt_div.sv =====
// ----------------------------------------------------------------------------
// tprt_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tprt_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tprt_pkg::PROD_W-1:0] dividend,
    input  logic [tprt_pkg::DEN_W-1:0]  divisor,
    output logic [tprt_pkg::PROD_W-1:0] quotient,
    output logic                        done
);

    localparam int QW    = tprt_pkg::PROD_W;
    localparam int DW    = tprt_pkg::DEN_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [DW:0]      rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;

    assign shifted = {rem_reg[DW-1:0], quo_reg[QW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(QW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DW+1])
            begin
                rem_reg <= diff[DW:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hw/rtl/tprt_dp.sv =====
// ----------------------------------------------------------------------------
// tprt_dp
// Datapath: configuration, move state, shared multiplier, divider and
// result registers.
// ----------------------------------------------------------------------------
module tprt_dp
#(
    parameter int TIME_WIDTH = tprt_pkg::TIME_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tprt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tprt_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  start_req,
    input  logic [tprt_pkg::TSTAMP_W-1:0]         time_now,
    output logic [tprt_pkg::SPEED_W-1:0]          linear_speed,
    output logic signed [tprt_pkg::ANG_W-1:0]     angular_speed,
    output logic [tprt_pkg::PHASE_W-1:0]          phase,
    output logic                                  finished,
    input  tprt_pkg::dp_cmd_t                     cmd,
    output tprt_pkg::dp_stat_t                    stat
);

    localparam int TW = TIME_WIDTH;
    localparam int TE = TIME_WIDTH + 1;
    localparam int SW = tprt_pkg::SPEED_W;
    localparam int LW = tprt_pkg::LEN_W;
    localparam int AW = tprt_pkg::MUL_A_W;
    localparam int BW = tprt_pkg::MUL_B_W;
    localparam int PW = tprt_pkg::PROD_W;
    localparam int NW = tprt_pkg::DEN_W;
    localparam int RW = tprt_pkg::RCP_IN_W;
    localparam logic [63:0] TMAX = (TW >= 64) ? {64{1'b1}} : ((64'd1 << TW) - 64'd1);

    typedef enum logic [1:0] {
        KIND_ACC,
        KIND_DEC,
        KIND_TURN
    } job_kind_t;

    logic [SW-1:0] max_speed_reg, accel_reg, max_turn_rate_reg;
    logic [LW-1:0] len_first_reg, len_curve_reg, len_second_reg;
    logic [tprt_pkg::DIR_W-1:0] turn_dir_reg;

    logic [tprt_pkg::PHASE_W-1:0] phase_reg;
    logic [TW-1:0] move_start_reg, accel_time_reg, cruise_time_reg;
    logic [TW-1:0] curve_offset_reg, ramp_time_reg, tnow_reg;

    logic [31:0] vsq_reg, vmac_reg;
    logic [37:0] total_reg, first_reg;
    logic [PW-1:0] prod_reg;

    logic [AW-1:0] it_a_reg;
    logic [BW-1:0] it_b_reg;
    logic [NW-1:0] it_den_reg;
    job_kind_t     it_kind_reg;

    logic [RW-1:0] rcp_in_reg;

    logic [SW-1:0] spd_res_reg, w_res_reg;
    logic [tprt_pkg::PHASE_W-1:0] ph_res_reg;

    logic [SW-1:0] linear_speed_reg;
    logic [tprt_pkg::ANG_W-1:0] angular_speed_reg;
    logic [tprt_pkg::PHASE_W-1:0] phase_out_reg;
    logic finished_reg;

    logic [SW-1:0] vm, ac;
    logic [TW-1:0] tnow_w;
    logic [21:0]   sum_len;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [NW-1:0] den;
    logic [PW-1:0] dividend;
    logic [PW-1:0] quotient;
    logic          div_done;
    logic [63:0]   q64;
    logic [63:0]   q_sat64;
    logic [TW-1:0] q_sat;
    logic          skip;
    logic [RW+31:0] rcp_prod;
    logic [SW-1:0]  rcp_q;

    logic [TW-1:0] dt, dc, x;
    logic [TE-1:0] base, dd, xe, re, r2;
    logic [63:0]   ev_a64, ramp64;
    logic [TE-1:0] ev_a;
    logic [tprt_pkg::PHASE_W-1:0] ev_phase, ev_ph;
    logic [SW-1:0] ev_spd;
    logic          ev_need;
    job_kind_t     ev_kind;
    logic [tprt_pkg::ANG_W-1:0] w17;

    assign vm      = (max_speed_reg == '0) ? SW'(1) : max_speed_reg;
    assign ac      = (accel_reg == '0) ? SW'(1) : accel_reg;
    assign tnow_w  = TW'(64'(time_now));
    assign sum_len = {2'b00, len_first_reg} + {1'b0, len_curve_reg, 1'b0}
                     + {2'b00, len_second_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        den   = NW'(ac);
        case (cmd.step)
            tprt_pkg::STEP_VSQ:
            begin
                mul_a = AW'(vm);
                mul_b = BW'(vm);
            end
            tprt_pkg::STEP_VMAC:
            begin
                mul_a = AW'(vm);
                mul_b = BW'(ac);
            end
            tprt_pkg::STEP_TOTAL:
            begin
                mul_a = AW'(sum_len);
                mul_b = BW'(ac);
            end
            tprt_pkg::STEP_FIRST:
            begin
                mul_a = AW'(len_first_reg);
                mul_b = BW'(ac);
            end
            tprt_pkg::STEP_ATIME:
            begin
                mul_a = AW'(vm);
                mul_b = tprt_pkg::US_PER_S;
                den   = NW'(ac);
            end
            tprt_pkg::STEP_CTIME:
            begin
                mul_a = AW'(total_reg - {6'd0, vsq_reg});
                mul_b = tprt_pkg::US_PER_S;
                den   = NW'(vmac_reg);
            end
            tprt_pkg::STEP_COFF:
            begin
                mul_a = AW'(first_reg - {6'd0, vsq_reg});
                mul_b = tprt_pkg::US_PER_S;
                den   = NW'({vmac_reg, 1'b0});
            end
            tprt_pkg::STEP_RTIME:
            begin
                mul_a = AW'(len_curve_reg);
                mul_b = tprt_pkg::US_PER_S;
                den   = NW'(vm);
            end
            tprt_pkg::STEP_ITEM:
            begin
                mul_a = it_a_reg;
                mul_b = it_b_reg;
                den   = it_den_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign dividend = (cmd.step == tprt_pkg::STEP_ITEM && it_kind_reg == KIND_DEC)
                      ? prod_reg + tprt_pkg::ROUND_UP : prod_reg;

    assign skip = (cmd.step == tprt_pkg::STEP_CTIME && !(total_reg > {6'd0, vsq_reg}))
               || (cmd.step == tprt_pkg::STEP_COFF && !(first_reg > {6'd0, vsq_reg}));

    tprt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (den),
        .quotient (quotient),
        .done     (div_done)
    );

    assign rcp_prod = {32'd0, rcp_in_reg} * {{RW{1'b0}}, tprt_pkg::RCP_MUL};
    assign rcp_q    = rcp_prod[tprt_pkg::RCP_SHIFT +: SW];

    assign q64     = 64'(quotient);
    assign q_sat64 = (q64 > TMAX) ? TMAX : q64;
    assign q_sat   = q_sat64[TW-1:0];

    assign dt     = tnow_reg - move_start_reg;
    assign dc     = (dt >= accel_time_reg) ? dt - accel_time_reg : '0;
    assign base   = {1'b0, accel_time_reg} + {1'b0, cruise_time_reg};
    assign dd     = ({1'b0, dt} >= base) ? {1'b0, dt} - base : '0;
    assign x      = dc - curve_offset_reg;
    assign xe     = {1'b0, x};
    assign re     = {1'b0, ramp_time_reg};
    assign r2     = {ramp_time_reg, 1'b0};
    assign ev_a64 = 64'(ev_a);
    assign ramp64 = 64'(ramp_time_reg);

    always_comb
    begin
        ev_phase = phase_reg;
        ev_ph    = phase_reg;
        ev_spd   = '0;
        ev_need  = 1'b0;
        ev_kind  = KIND_ACC;
        ev_a     = '0;
        case (phase_reg)
            tprt_pkg::PH_ACCEL:
            begin
                if (dt >= accel_time_reg)
                begin
                    ev_spd   = vm;
                    ev_phase = tprt_pkg::PH_CRUISE;
                end
                else
                begin
                    ev_need = 1'b1;
                    ev_kind = KIND_ACC;
                    ev_a    = {1'b0, dt};
                end
            end
            tprt_pkg::PH_CRUISE:
            begin
                ev_spd = vm;
                if (dc >= cruise_time_reg)
                begin
                    ev_phase = tprt_pkg::PH_DECEL;
                end
                if (ramp_time_reg != '0 && dc >= curve_offset_reg)
                begin
                    if (xe <= re)
                    begin
                        ev_need = 1'b1;
                        ev_kind = KIND_TURN;
                        ev_a    = xe;
                    end
                    else if (xe <= r2)
                    begin
                        ev_need = 1'b1;
                        ev_kind = KIND_TURN;
                        ev_a    = r2 - xe;
                    end
                end
            end
            tprt_pkg::PH_DECEL:
            begin
                if (dd >= {1'b0, accel_time_reg})
                begin
                    ev_phase = tprt_pkg::PH_DONE;
                end
                else
                begin
                    ev_need = 1'b1;
                    ev_kind = KIND_DEC;
                    ev_a    = dd;
                end
            end
            tprt_pkg::PH_DONE:
            begin
                ev_phase = tprt_pkg::PH_DONE;
            end
            default:
            begin
                ev_phase = tprt_pkg::PH_IDLE;
                ev_ph    = tprt_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg     <= SW'(500);
            accel_reg         <= SW'(250);
            max_turn_rate_reg <= SW'(1000);
            len_first_reg     <= '0;
            len_curve_reg     <= LW'(1);
            len_second_reg    <= '0;
            turn_dir_reg      <= 2'b01;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tprt_pkg::REG_MAX_SPEED:     max_speed_reg     <= cfg_data[SW-1:0];
                tprt_pkg::REG_ACCEL:         accel_reg         <= cfg_data[SW-1:0];
                tprt_pkg::REG_MAX_TURN_RATE: max_turn_rate_reg <= cfg_data[SW-1:0];
                tprt_pkg::REG_LEN_FIRST:     len_first_reg     <= cfg_data[LW-1:0];
                tprt_pkg::REG_LEN_CURVE:     len_curve_reg     <= cfg_data[LW-1:0];
                tprt_pkg::REG_LEN_SECOND:    len_second_reg    <= cfg_data[LW-1:0];
                tprt_pkg::REG_TURN_DIR:      turn_dir_reg      <= cfg_data[tprt_pkg::DIR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= tprt_pkg::PH_IDLE;
            move_start_reg   <= '0;
            accel_time_reg   <= '0;
            cruise_time_reg  <= '0;
            curve_offset_reg <= '0;
            ramp_time_reg    <= '0;
        end
        else
        begin
            if (cmd.load_in && start_req)
            begin
                move_start_reg <= tnow_w;
                phase_reg      <= tprt_pkg::PH_ACCEL;
            end
            if (cmd.eval)
            begin
                phase_reg <= ev_phase;
            end
            if (cmd.store)
            begin
                case (cmd.step)
                    tprt_pkg::STEP_ATIME: accel_time_reg   <= q_sat;
                    tprt_pkg::STEP_CTIME: cruise_time_reg  <= skip ? '0 : q_sat;
                    tprt_pkg::STEP_COFF:  curve_offset_reg <= skip ? '0 : q_sat;
                    tprt_pkg::STEP_RTIME: ramp_time_reg    <= q_sat;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            tnow_reg <= tnow_w;
            if (start_req)
            begin
                spd_res_reg <= '0;
                w_res_reg   <= '0;
                ph_res_reg  <= tprt_pkg::PH_ACCEL;
            end
        end
        if (cmd.eval)
        begin
            spd_res_reg <= ev_spd;
            w_res_reg   <= '0;
            ph_res_reg  <= ev_ph;
            it_kind_reg <= ev_kind;
            it_a_reg    <= ev_a64[AW-1:0];
            it_b_reg    <= (ev_kind == KIND_TURN) ? BW'(max_turn_rate_reg) : BW'(ac);
            it_den_reg  <= (ev_kind == KIND_TURN) ? ramp64[NW-1:0] : NW'(tprt_pkg::US_PER_S);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PW'(mul_a) * PW'(mul_b);
        end
        if (cmd.rcp_load)
        begin
            rcp_in_reg <= dividend[tprt_pkg::RCP_PRE +: RW];
        end
        if (cmd.store)
        begin
            case (cmd.step)
                tprt_pkg::STEP_VSQ:   vsq_reg   <= prod_reg[31:0];
                tprt_pkg::STEP_VMAC:  vmac_reg  <= prod_reg[31:0];
                tprt_pkg::STEP_TOTAL: total_reg <= prod_reg[37:0];
                tprt_pkg::STEP_FIRST: first_reg <= {prod_reg[36:0], 1'b0};
                tprt_pkg::STEP_ITEM:
                begin
                    case (it_kind_reg)
                        KIND_ACC: spd_res_reg <= rcp_q;
                        KIND_DEC: spd_res_reg <= vm - rcp_q;
                        default:  w_res_reg   <= quotient[SW-1:0];
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.out_load)
        begin
            linear_speed_reg  <= spd_res_reg;
            angular_speed_reg <= w17;
            phase_out_reg     <= ph_res_reg;
            finished_reg      <= (ph_res_reg == tprt_pkg::PH_DONE);
        end
    end

    always_comb
    begin
        if (turn_dir_reg[1])
        begin
            w17 = '0 - {1'b0, w_res_reg};
        end
        else if (turn_dir_reg == 2'b01)
        begin
            w17 = {1'b0, w_res_reg};
        end
        else
        begin
            w17 = '0;
        end
    end

    assign stat.start     = start_req;
    assign stat.need_job  = ev_need;
    assign stat.skip      = skip;
    assign stat.const_div = (cmd.step == tprt_pkg::STEP_ITEM) && (it_kind_reg != KIND_TURN);
    assign stat.div_done  = div_done;

    assign linear_speed  = linear_speed_reg;
    assign angular_speed = angular_speed_reg;
    assign phase         = phase_out_reg;
    assign finished      = finished_reg;

endmodule

// ===== hw/rtl/tprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tprt_ctrl
// Sequencer: steps the datapath through move planning and per-beat
// evaluation, and owns both handshakes.
// ----------------------------------------------------------------------------
module tprt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output tprt_pkg::dp_cmd_t  cmd,
    input  tprt_pkg::dp_stat_t stat
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_POST = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_RCP  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    tprt_pkg::step_t step_reg, step_next;
    logic            out_valid_reg, out_valid_next;
    logic            prod_only;

    function automatic tprt_pkg::step_t step_succ(input tprt_pkg::step_t s);
        tprt_pkg::step_t n;
        case (s)
            tprt_pkg::STEP_VSQ:   n = tprt_pkg::STEP_VMAC;
            tprt_pkg::STEP_VMAC:  n = tprt_pkg::STEP_TOTAL;
            tprt_pkg::STEP_TOTAL: n = tprt_pkg::STEP_FIRST;
            tprt_pkg::STEP_FIRST: n = tprt_pkg::STEP_ATIME;
            tprt_pkg::STEP_ATIME: n = tprt_pkg::STEP_CTIME;
            tprt_pkg::STEP_CTIME: n = tprt_pkg::STEP_COFF;
            tprt_pkg::STEP_COFF:  n = tprt_pkg::STEP_RTIME;
            default:              n = tprt_pkg::STEP_ITEM;
        endcase
        return n;
    endfunction

    assign prod_only = (step_reg == tprt_pkg::STEP_VSQ) || (step_reg == tprt_pkg::STEP_VMAC)
                    || (step_reg == tprt_pkg::STEP_TOTAL) || (step_reg == tprt_pkg::STEP_FIRST);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (stat.start)
                    begin
                        step_next  = tprt_pkg::STEP_VSQ;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (stat.need_job)
                begin
                    step_next  = tprt_pkg::STEP_ITEM;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (prod_only || stat.skip)
                begin
                    cmd.store  = 1'b1;
                    step_next  = step_succ(step_reg);
                    state_next = S_MUL;
                end
                else if (stat.const_div)
                begin
                    cmd.rcp_load = 1'b1;
                    state_next   = S_RCP;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_RCP:
            begin
                cmd.store  = 1'b1;
                state_next = S_FIN;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.store = 1'b1;
                    if (step_reg == tprt_pkg::STEP_RTIME || step_reg == tprt_pkg::STEP_ITEM)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        step_next  = step_succ(step_reg);
                        state_next = S_MUL;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= tprt_pkg::STEP_VSQ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !stat.div_done)
        else $error("divider reports done right after start");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register loaded while holding a stalled beat");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted beat did not start work");

endmodule

// ===== hw/rtl/trapezoid_profile_with_turn_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// trapezoid_profile_with_turn_ramp_unit
// Trapezoidal path speed profile with a triangular turn-rate ramp in cruise.
// ----------------------------------------------------------------------------
// One beat is in work at a time. A timestamp beat needs a turn-rate division,
// an accel or decel speed (a divide by one million done with a reciprocal
// multiply) or neither; the input is taken again in the cycle after the
// result is loaded. A start beat plans the move; the cruise time and curve
// offset divisions are skipped when those values clamp to zero. The shared
// radix-2 divider runs for the turn rate and for up to four plan divisions.
// A finished beat waits in the output register while the next input beat is
// taken.
module trapezoid_profile_with_turn_ramp_unit
#(
    parameter int TIME_WIDTH = tprt_pkg::TIME_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tprt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tprt_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_req,
    input  logic [tprt_pkg::TSTAMP_W-1:0]       time_now,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tprt_pkg::SPEED_W-1:0]        linear_speed,
    output logic signed [tprt_pkg::ANG_W-1:0]   angular_speed,
    output logic [tprt_pkg::PHASE_W-1:0]        phase,
    output logic                                finished
);

    tprt_pkg::dp_cmd_t  cmd;
    tprt_pkg::dp_stat_t stat;

    tprt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    tprt_dp #(.TIME_WIDTH(TIME_WIDTH)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start_req     (start_req),
        .time_now      (time_now),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed),
        .phase         (phase),
        .finished      (finished),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ===== bench/trapezoid_profile_with_turn_ramp_unit_tb.sv =====
// ----------------------------------------------------------------------------
// trapezoid_profile_with_turn_ramp_unit_tb
// Self-checking bench for the trapezoid profile unit. Each accepted input
// beat runs through a behavioral copy of the speed and turn-rate profile.
// Every output beat is compared field by field with the oldest prediction.
// The bench covers directed phase walks, register extremes, randomized moves
// under random idling, and a long output hold that backs up the input side.
// ----------------------------------------------------------------------------
module trapezoid_profile_with_turn_ramp_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned TMAX      = 64'hFFFF_FFFF;
    localparam longint unsigned USEC      = 64'd1000000;
    localparam int              CYCLE_CAP = 4000000;

    typedef struct packed {
        logic [tprt_pkg::SPEED_W-1:0] spd;
        logic [tprt_pkg::ANG_W-1:0]   ang;
        logic [tprt_pkg::PHASE_W-1:0] ph;
        logic                         fin;
    } motion_cmd_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [tprt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tprt_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           start_req = 1'b0;
    logic [tprt_pkg::TSTAMP_W-1:0]  time_now = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [tprt_pkg::SPEED_W-1:0]   linear_speed;
    logic signed [tprt_pkg::ANG_W-1:0] angular_speed;
    logic [tprt_pkg::PHASE_W-1:0]   phase;
    logic                           finished;

    // profile registers and move state
    longint unsigned r_vmax, r_accel, r_wmax, r_len1, r_lenk, r_len2;
    logic [1:0]      r_dir;
    logic [2:0]      mv_phase;
    logic [31:0]     mv_start;
    longint unsigned t_accel, t_cruise, t_offset, t_ramp;

    motion_cmd_t cmd_q[$];
    int          errors = 0;
    int          cycles = 0;
    bit          no_idle = 0;
    bit          hold_req = 0;

    trapezoid_profile_with_turn_ramp_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_req(start_req), .time_now(time_now),
        .out_valid(out_valid), .out_stall(out_stall),
        .linear_speed(linear_speed), .angular_speed(angular_speed),
        .phase(phase), .finished(finished)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic longint unsigned sat_time(longint unsigned v);
        return v > TMAX ? TMAX : v;
    endfunction

    function automatic longint unsigned eff_vmax();
        return r_vmax == 0 ? 64'd1 : r_vmax;
    endfunction

    function automatic longint unsigned eff_accel();
        return r_accel == 0 ? 64'd1 : r_accel;
    endfunction

    function automatic void plan_profile();
        longint unsigned vm, ac, vsq, tot, fst;
        vm  = eff_vmax();
        ac  = eff_accel();
        vsq = vm * vm;
        tot = (r_len1 + 2 * r_lenk + r_len2) * ac;
        fst = 2 * r_len1 * ac;
        t_accel  = sat_time(vm * USEC / ac);
        t_cruise = tot > vsq ? sat_time((tot - vsq) * USEC / (vm * ac)) : 0;
        t_offset = fst > vsq ? sat_time((fst - vsq) * USEC / (2 * vm * ac)) : 0;
        t_ramp   = sat_time(r_lenk * USEC / vm);
    endfunction

    function automatic longint unsigned turn_ramp(longint unsigned dc);
        longint unsigned x;
        if (t_ramp == 0 || dc < t_offset)
            return 0;
        x = dc - t_offset;
        if (x <= t_ramp)
            return r_wmax * x / t_ramp;
        if (x <= 2 * t_ramp)
            return r_wmax * (2 * t_ramp - x) / t_ramp;
        return 0;
    endfunction

    function automatic motion_cmd_t predict_cmd(logic st, logic [31:0] tn);
        motion_cmd_t     c;
        logic [31:0]     d32;
        longint unsigned dt, dc, dd, spd, w, vm, ac;
        logic [2:0]      ph;
        logic [16:0]     w17;
        vm  = eff_vmax();
        ac  = eff_accel();
        spd = 0;
        w   = 0;
        ph  = mv_phase;
        if (st)
        begin
            mv_start = tn;
            plan_profile();
            mv_phase = tprt_pkg::PH_ACCEL;
            ph = tprt_pkg::PH_ACCEL;
        end
        else
        begin
            d32 = tn - mv_start;
            dt  = d32;
            if (mv_phase == tprt_pkg::PH_ACCEL)
            begin
                if (dt >= t_accel)
                begin
                    spd = vm;
                    mv_phase = tprt_pkg::PH_CRUISE;
                end
                else
                    spd = ac * dt / USEC;
            end
            else if (mv_phase == tprt_pkg::PH_CRUISE)
            begin
                dc  = dt >= t_accel ? dt - t_accel : 0;
                spd = vm;
                w   = turn_ramp(dc);
                if (dc >= t_cruise)
                    mv_phase = tprt_pkg::PH_DECEL;
            end
            else if (mv_phase == tprt_pkg::PH_DECEL)
            begin
                dd = dt >= t_accel + t_cruise ? dt - (t_accel + t_cruise) : 0;
                if (dd >= t_accel)
                begin
                    spd = 0;
                    mv_phase = tprt_pkg::PH_DONE;
                end
                else
                    spd = (vm * USEC - ac * dd) / USEC;
            end
            else if (mv_phase != tprt_pkg::PH_DONE)
            begin
                mv_phase = tprt_pkg::PH_IDLE;
                ph = tprt_pkg::PH_IDLE;
            end
        end
        w17 = w[16:0];
        if (r_dir[1])
            c.ang = 17'd0 - w17;
        else if (r_dir == 2'd1)
            c.ang = w17;
        else
            c.ang = '0;
        c.spd = spd[15:0];
        c.ph  = ph;
        c.fin = (ph == tprt_pkg::PH_DONE);
        return c;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s at cycle %0d: got %0d, want %0d", field, cycles, got, want);
        errors++;
    endtask

    // check each output beat against the oldest prediction
    always @(posedge clk)
    begin
        motion_cmd_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cmd_q.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                e = cmd_q.pop_front();
                if (linear_speed !== e.spd)
                    report_mismatch("linear_speed", linear_speed, e.spd);
                if (angular_speed !== e.ang)
                    report_mismatch("angular_speed", angular_speed, $signed(e.ang));
                if (phase !== e.ph)
                    report_mismatch("phase", phase, e.ph);
                if (finished !== e.fin)
                    report_mismatch("finished", finished, e.fin);
            end
        end
    end

    // output side: random stalls, one long hold on request
    initial
    begin
        int n;
        int hold_cnt;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_stall <= 1'b1;
                hold_cnt = 0;
                while (hold_cnt < 3000)
                begin
                    @(posedge clk);
                    hold_cnt++;
                end
            end
            else
            begin
                n = no_idle ? 0 : $urandom_range(0, 10);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_beat(logic st, logic [31:0] tn);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= st;
        time_now  <= tn;
        do @(posedge clk); while (in_stall);
        cmd_q.push_back(predict_cmd(st, tn));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (cmd_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [tprt_pkg::CFG_IDX_W-1:0] idx,
                             logic [tprt_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            tprt_pkg::REG_MAX_SPEED:     r_vmax  = val[15:0];
            tprt_pkg::REG_ACCEL:         r_accel = val[15:0];
            tprt_pkg::REG_MAX_TURN_RATE: r_wmax  = val[15:0];
            tprt_pkg::REG_LEN_FIRST:     r_len1  = val;
            tprt_pkg::REG_LEN_CURVE:     r_lenk  = val;
            tprt_pkg::REG_LEN_SECOND:    r_len2  = val;
            tprt_pkg::REG_TURN_DIR:      r_dir   = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_profile(logic [19:0] vm, logic [19:0] ac, logic [19:0] wm,
                               logic [19:0] l1, logic [19:0] lk, logic [19:0] l2,
                               logic [19:0] dir);
        write_reg(tprt_pkg::REG_MAX_SPEED, vm);
        write_reg(tprt_pkg::REG_ACCEL, ac);
        write_reg(tprt_pkg::REG_MAX_TURN_RATE, wm);
        write_reg(tprt_pkg::REG_LEN_FIRST, l1);
        write_reg(tprt_pkg::REG_LEN_CURVE, lk);
        write_reg(tprt_pkg::REG_LEN_SECOND, l2);
        write_reg(tprt_pkg::REG_TURN_DIR, dir);
    endtask

    // one start beat then timestamps walking through the whole profile
    task automatic run_move(int n, bit noisy);
        logic [31:0]     t0, t;
        longint unsigned span, stepw;
        t0 = $urandom;
        send_beat(1'b1, t0);
        span = 2 * t_accel + t_cruise;
        span = span + span / 5 + 1;
        if (span > TMAX)
            span = TMAX;
        stepw = span / n + 1;
        t = t0;
        for (int k = 0; k < n; k++)
        begin
            t = t + 32'(stepw * $urandom_range(0, 200) / 100);
            if (noisy && $urandom_range(0, 9) == 0)
                send_beat($urandom_range(0, 3) == 0, $urandom);
            else
                send_beat(1'b0, t);
        end
    endtask

    task automatic test_directed();
        send_beat(1'b0, 32'd5);
        send_beat(1'b0, 32'hFFFF_FFFF);
        send_beat(1'b1, 32'd100);
        send_beat(1'b0, 32'd100);
        send_beat(1'b0, 32'd1000100);
        send_beat(1'b0, 32'd2000100);
        send_beat(1'b0, 32'd2001100);
        send_beat(1'b0, 32'd3000100);
        send_beat(1'b0, 32'd4000100);
        send_beat(1'b0, 32'd4000200);
        send_beat(1'b1, 32'hFFFF_FF00);
        send_beat(1'b0, 32'h0000_0010);
        send_beat(1'b0, 32'hFFFF_FE00);
        drain();
        set_profile(20'd1000, 20'd1000, 20'd2000, 20'd1000, 20'd500, 20'd1000, 20'd3);
        send_beat(1'b1, 32'd0);
        send_beat(1'b0, 32'd500000);
        send_beat(1'b0, 32'd1000000);
        send_beat(1'b0, 32'd1600000);
        send_beat(1'b0, 32'd2000000);
        send_beat(1'b0, 32'd2400000);
        send_beat(1'b1, 32'd2500000);
        send_beat(1'b0, 32'd9000000);
        send_beat(1'b0, 32'd9000001);
        send_beat(1'b0, 32'd9500000);
        send_beat(1'b0, 32'd20000000);
        drain();
    endtask

    task automatic test_reg_extremes();
        set_profile(20'd0, 20'd0, 20'd65535, 20'd0, 20'd1, 20'd0, 20'd2);
        run_move(8, 0);
        drain();
        set_profile(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        run_move(8, 0);
        drain();
        set_profile(20'd65535, 20'd1, 20'd0, 20'd1000000, 20'd1000000, 20'd1000000, 20'd0);
        run_move(8, 0);
        drain();
        set_profile(20'd1, 20'd65535, 20'd65535, 20'd3, 20'd2, 20'd0, 20'd1);
        run_move(8, 0);
        drain();
    endtask

    task automatic test_random_moves();
        logic [19:0] v[7];
        for (int s = 0; s < 12; s++)
        begin
            no_idle = (s % 4 == 3);
            v[0] = $urandom_range(0, 7) == 0 ? 20'($urandom) : 20'($urandom_range(1, 2000));
            v[1] = $urandom_range(0, 7) == 0 ? 20'($urandom) : 20'($urandom_range(1, 2000));
            v[2] = 20'($urandom);
            v[3] = $urandom_range(0, 7) == 0 ? 20'($urandom) : 20'($urandom_range(0, 3000));
            v[4] = $urandom_range(0, 7) == 0 ? 20'($urandom) : 20'($urandom_range(0, 1500));
            v[5] = $urandom_range(0, 7) == 0 ? 20'($urandom) : 20'($urandom_range(0, 3000));
            v[6] = 20'($urandom_range(0, 3));
            set_profile(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
            for (int m = 0; m < 4; m++)
                run_move($urandom_range(8, 18), 1);
            drain();
        end
        no_idle = 0;
    endtask

    task automatic test_backpressure();
        set_profile(20'd800, 20'd400, 20'd1500, 20'd2000, 20'd800, 20'd1500, 20'd1);
        hold_req = 1;
        run_move(30, 0);
        drain();
        run_move(20, 1);
        drain();
    endtask

    initial
    begin
        r_vmax = 500; r_accel = 250; r_wmax = 1000;
        r_len1 = 0; r_lenk = 1; r_len2 = 0; r_dir = 2'd1;
        mv_phase = tprt_pkg::PH_IDLE; mv_start = '0;
        t_accel = 0; t_cruise = 0; t_offset = 0; t_ramp = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_reg_extremes();
        test_random_moves();
        test_backpressure();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tprt_pkg.sv
hw/rtl/tprt_div.sv
hw/rtl/tprt_dp.sv
hw/rtl/tprt_ctrl.sv
hw/rtl/trapezoid_profile_with_turn_ramp_unit.sv
bench/trapezoid_profile_with_turn_ramp_unit_tb.sv
